>>> rtl/bvg_pkg.sv
// ----------------------------------------------------------------------------
// bvg_pkg
// Shared types, register indexes, reset values and curve helpers for the
// battery voltage gauge.
// ----------------------------------------------------------------------------
package bvg_pkg;

  // field widths
  localparam int MV_W    = 14;
  localparam int PCT_W   = 7;
  localparam int ANC_W   = 21;
  localparam int CURVE_W = 42;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CURVE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MV  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MV  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST    = 3'd6;

  // register reset values
  localparam logic [MV_W-1:0]  MIN_MV_RST = 14'd3000;
  localparam logic [MV_W-1:0]  MAX_MV_RST = 14'd4500;
  localparam logic [PCT_W-1:0] HYST_RST   = 7'd2;

  // curve and averaging, the scale is a power of two
  localparam int ANCHORS_DEF = 8;
  localparam int EMA_WEIGHT  = 1;
  localparam int EMA_SCALE   = 8;
  localparam int EMA_DIVD_W  = 19;

  // divider step count: quotient bits of the interpolation
  localparam int DIV_CNT_W = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_PCT_STEPS = 4'd8;

  // upper six bits of the voltage sit in the low bits of the first byte
  localparam logic [7:0] VHI_MASK = 8'h3F;

  typedef struct packed {
    logic       voltage_ok;
    logic [7:0] voltage_high;
    logic [7:0] voltage_low;
    logic       status_one_ok;
    logic [7:0] status_one;
    logic       status_two_ok;
    logic [7:0] status_two;
  } bvg_in_t;

  typedef struct packed {
    logic             reading_valid;
    logic [MV_W-1:0]  filtered_mv;
    logic [PCT_W-1:0] shown_pct;
    logic             sample_rejected;
    logic             shown_changed;
    logic [7:0]       status_one_seen;
    logic [7:0]       status_two_seen;
  } bvg_out_t;

  // one anchor word: even anchor in the low half of a register
  function automatic logic [ANC_W-1:0] anchor_word(input logic [3:0][CURVE_W-1:0] curve,
                                                   input logic [2:0] k);
    logic [CURVE_W-1:0] pair;
    pair = curve[k[2:1]];
    return k[0] ? pair[CURVE_W-1:ANC_W] : pair[ANC_W-1:0];
  endfunction

  function automatic logic [MV_W-1:0] anchor_mv(input logic [ANC_W-1:0] w);
    return w[MV_W-1:0];
  endfunction

  function automatic logic [PCT_W-1:0] anchor_pct(input logic [ANC_W-1:0] w);
    return w[ANC_W-1:MV_W];
  endfunction

endpackage

>>> rtl/bvg_chan_if.sv
// ----------------------------------------------------------------------------
// bvg_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface bvg_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/battery_voltage_gauge_core.sv
// ----------------------------------------------------------------------------
// battery_voltage_gauge_core
// Voltage based battery gauge: window check, exponential average, curve
// lookup with interpolation and hysteresis on the shown percent.
// ----------------------------------------------------------------------------
// One poll is handled at a time and in_chan.ready is high only while the
// sequencer is idle. A failed voltage read or a rejected sample goes from the
// check state straight to the output register load; an accepted sample then
// goes through the curve lookup and hysteresis, with no walk when the average
// lies at or beyond an end of the curve and no interpolation on a flat segment.
// The time is set by the anchor walk, one compare per cycle, and by the
// restoring divider, which makes one quotient bit per cycle over 8 steps for
// the interpolation; the average divides by its power-of-two scale with a shift.
// The result sits in an output register, so the next poll can be taken the
// cycle after while the previous result still waits; a result that cannot
// be loaded holds the sequencer until the output register frees up.
// Configuration writes go to plain registers and are meant to happen while
// no poll is in flight.
module battery_voltage_gauge_core #(
  parameter int ANCHORS = bvg_pkg::ANCHORS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bvg_chan_if.sink                          in_chan,
  bvg_chan_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [bvg_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [bvg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bvg_pkg::*;

  localparam int IDX_W = $clog2(ANCHORS);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(ANCHORS - 1);
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
  localparam bit EMA_BYPASS = (EMA_WEIGHT >= EMA_SCALE);
  localparam logic [4:0] EMA_KEEP = 5'(EMA_SCALE - EMA_WEIGHT);
  localparam logic [4:0] EMA_NEW  = 5'(EMA_WEIGHT);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_DIV   = 11'b00000000100,
    S_TOP   = 11'b00000001000,
    S_BOT   = 11'b00000010000,
    S_WALK  = 11'b00000100000,
    S_MUL   = 11'b00001000000,
    S_LOAD  = 11'b00010000000,
    S_APPLY = 11'b00100000000,
    S_HYST  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } bvg_state_t;

  // control and status state
  bvg_state_t           state_r, state_nxt;
  bvg_in_t              inp_r, inp_nxt;
  logic [3:0][CURVE_W-1:0] curve_r, curve_nxt;
  logic [MV_W-1:0]      min_mv_r, min_mv_nxt;
  logic [MV_W-1:0]      max_mv_r, max_mv_nxt;
  logic [PCT_W-1:0]     hyst_r, hyst_nxt;
  logic [MV_W-1:0]      ema_r, ema_nxt;
  logic [PCT_W-1:0]     pct_r, pct_nxt;
  logic                 have_r, have_nxt;
  logic [7:0]           seen1_r, seen1_nxt;
  logic [7:0]           seen2_r, seen2_nxt;
  logic                 rej_r, rej_nxt;
  logic                 chg_r, chg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  bvg_out_t             out_r, out_nxt;

  // curve walk and interpolation
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [PCT_W-1:0]     seg_pct_r, seg_pct_nxt;
  logic [MV_W-1:0]      up_r, up_nxt;
  logic [MV_W-1:0]      span_mv_r, span_mv_nxt;
  logic signed [7:0]    rise_pct_r, rise_pct_nxt;
  logic signed [21:0]   prod_r, prod_nxt;
  logic                 neg_r, neg_nxt;
  logic [PCT_W-1:0]     new_pct_r, new_pct_nxt;

  // restoring divider
  logic [MV_W-1:0]      rem_r, rem_nxt;
  logic [MV_W-1:0]      shf_r, shf_nxt;
  logic [MV_W-1:0]      div_r, div_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  // combinational helpers
  logic [MV_W-1:0]      raw_mv;
  logic [2:0]           sel_k;
  logic [ANC_W-1:0]     anc_w, prev_w;
  logic [MV_W:0]        div_cat;
  logic                 div_ge;
  logic [MV_W-1:0]      div_rem_step;
  logic [MV_W-1:0]      div_shf_step;
  logic [EMA_DIVD_W-1:0] ema_divd;
  logic signed [14:0]   up_s;
  logic signed [22:0]   num_s;
  logic [20:0]          num_mag;
  logic signed [9:0]    q_s, v_s;
  logic signed [8:0]    diff_s, h_s;

  assign raw_mv = {inp_r.voltage_high[5:0] & VHI_MASK[5:0], inp_r.voltage_low};

  // anchor selection for the walk
  always_comb begin
    case (state_r)
      S_TOP:   sel_k = 3'd0;
      S_BOT:   sel_k = 3'(IDX_LAST);
      default: sel_k = 3'(idx_r);
    endcase
  end

  assign anc_w  = anchor_word(curve_r, sel_k);
  assign prev_w = anchor_word(curve_r, 3'(idx_r - IDX_FIRST));

  // one divider step
  assign div_cat      = {rem_r, shf_r[MV_W-1]};
  assign div_ge       = (div_cat >= {1'b0, div_r});
  assign div_rem_step = div_ge ? MV_W'(div_cat - {1'b0, div_r}) : div_cat[MV_W-1:0];
  assign div_shf_step = {shf_r[MV_W-2:0], div_ge};

  // weighted average numerator
  assign ema_divd = EMA_DIVD_W'(ema_r) * EMA_DIVD_W'(EMA_KEEP)
                  + EMA_DIVD_W'(raw_mv) * EMA_DIVD_W'(EMA_NEW);

  // interpolation numerator with rounding term, as sign and magnitude
  assign up_s    = $signed({1'b0, up_r});
  assign num_s   = prod_r + $signed({10'b0, span_mv_r[MV_W-1:1]});
  assign num_mag = num_s[22] ? 21'(-num_s) : 21'(num_s);

  // signed quotient added to the lower anchor percent
  assign q_s = neg_r ? -$signed({2'b0, shf_r[7:0]}) : $signed({2'b0, shf_r[7:0]});
  assign v_s = $signed({3'b0, seg_pct_r}) + q_s;

  // hysteresis distance
  assign diff_s = $signed({2'b0, new_pct_r}) - $signed({2'b0, pct_r});
  assign h_s    = $signed({2'b0, hyst_r});

  // configuration writes
  always_comb begin
    curve_nxt  = curve_r;
    min_mv_nxt = min_mv_r;
    max_mv_nxt = max_mv_r;
    hyst_nxt   = hyst_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_CURVE_A: curve_nxt[0] = cfg_wdata;
        CFG_CURVE_B: curve_nxt[1] = cfg_wdata;
        CFG_CURVE_C: curve_nxt[2] = cfg_wdata;
        CFG_CURVE_D: curve_nxt[3] = cfg_wdata;
        CFG_MIN_MV:  min_mv_nxt   = cfg_wdata[MV_W-1:0];
        CFG_MAX_MV:  max_mv_nxt   = cfg_wdata[MV_W-1:0];
        CFG_HYST:    hyst_nxt     = cfg_wdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    inp_nxt       = inp_r;
    ema_nxt       = ema_r;
    pct_nxt       = pct_r;
    have_nxt      = have_r;
    seen1_nxt     = seen1_r;
    seen2_nxt     = seen2_r;
    rej_nxt       = rej_r;
    chg_nxt       = chg_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    idx_nxt       = idx_r;
    seg_pct_nxt   = seg_pct_r;
    up_nxt        = up_r;
    span_mv_nxt   = span_mv_r;
    rise_pct_nxt  = rise_pct_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    new_pct_nxt   = new_pct_r;
    rem_nxt       = rem_r;
    shf_nxt       = shf_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;

    // result leaves on transfer
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          inp_nxt   = in_chan.payload;
          rej_nxt   = 1'b0;
          chg_nxt   = 1'b0;
          state_nxt = S_CHECK;
        end
      end

      // status masks, window check, average update
      S_CHECK: begin
        if (!inp_r.voltage_ok) begin
          state_nxt = S_DONE;
        end else begin
          if (inp_r.status_one_ok) seen1_nxt = seen1_r | inp_r.status_one;
          if (inp_r.status_two_ok) seen2_nxt = seen2_r | inp_r.status_two;
          if (raw_mv < min_mv_r || raw_mv > max_mv_r) begin
            rej_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else if (ema_r == '0 || EMA_BYPASS) begin
            ema_nxt   = raw_mv;
            state_nxt = S_TOP;
          end else begin
            ema_nxt   = MV_W'(ema_divd / EMA_SCALE);
            state_nxt = S_TOP;
          end
        end
      end

      // one quotient bit per cycle
      S_DIV: begin
        rem_nxt = div_rem_step;
        shf_nxt = div_shf_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          state_nxt = S_APPLY;
        end
      end

      // at or above the first anchor
      S_TOP: begin
        if (ema_r >= anchor_mv(anc_w)) begin
          new_pct_nxt = anchor_pct(anc_w);
          state_nxt   = S_HYST;
        end else begin
          state_nxt = S_BOT;
        end
      end

      // at or below the last anchor
      S_BOT: begin
        if (ema_r <= anchor_mv(anc_w)) begin
          new_pct_nxt = anchor_pct(anc_w);
          state_nxt   = S_HYST;
        end else begin
          idx_nxt   = IDX_FIRST;
          state_nxt = S_WALK;
        end
      end

      // find the segment that holds the average
      S_WALK: begin
        if (ema_r >= anchor_mv(anc_w)) begin
          seg_pct_nxt = anchor_pct(anc_w);
          if (anchor_mv(prev_w) <= anchor_mv(anc_w)) begin
            new_pct_nxt = anchor_pct(anc_w);
            state_nxt   = S_HYST;
          end else begin
            up_nxt       = ema_r - anchor_mv(anc_w);
            span_mv_nxt  = anchor_mv(prev_w) - anchor_mv(anc_w);
            rise_pct_nxt = $signed({1'b0, anchor_pct(prev_w)})
                         - $signed({1'b0, anchor_pct(anc_w)});
            state_nxt    = S_MUL;
          end
        end else begin
          idx_nxt = idx_r + IDX_FIRST;
        end
      end

      S_MUL: begin
        prod_nxt  = up_s * rise_pct_r;
        state_nxt = S_LOAD;
      end

      // quotient fits eight bits since the offset stays below the span
      S_LOAD: begin
        neg_nxt     = num_s[22];
        rem_nxt     = MV_W'(num_mag[20:8]);
        shf_nxt     = {num_mag[7:0], 6'b0};
        div_nxt     = span_mv_r;
        cnt_nxt     = DIV_PCT_STEPS;
        state_nxt   = S_DIV;
      end

      // clamp to the percent range
      S_APPLY: begin
        if (v_s < 0) begin
          new_pct_nxt = '0;
        end else if (v_s > 10'sd127) begin
          new_pct_nxt = '1;
        end else begin
          new_pct_nxt = v_s[PCT_W-1:0];
        end
        state_nxt = S_HYST;
      end

      S_HYST: begin
        if (!have_r || diff_s >= h_s || diff_s <= -h_s) begin
          pct_nxt  = new_pct_r;
          have_nxt = 1'b1;
          chg_nxt  = 1'b1;
        end
        state_nxt = S_DONE;
      end

      // load the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt           = 1'b1;
          out_nxt.reading_valid   = have_r;
          out_nxt.filtered_mv     = ema_r;
          out_nxt.shown_pct       = pct_r;
          out_nxt.sample_rejected = rej_r;
          out_nxt.shown_changed   = chg_r;
          out_nxt.status_one_seen = seen1_r;
          out_nxt.status_two_seen = seen2_r;
          state_nxt               = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      curve_r     <= '0;
      min_mv_r    <= MIN_MV_RST;
      max_mv_r    <= MAX_MV_RST;
      hyst_r      <= HYST_RST;
      ema_r       <= '0;
      pct_r       <= '0;
      have_r      <= 1'b0;
      seen1_r     <= '0;
      seen2_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      curve_r     <= curve_nxt;
      min_mv_r    <= min_mv_nxt;
      max_mv_r    <= max_mv_nxt;
      hyst_r      <= hyst_nxt;
      ema_r       <= ema_nxt;
      pct_r       <= pct_nxt;
      have_r      <= have_nxt;
      seen1_r     <= seen1_nxt;
      seen2_r     <= seen2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    inp_r      <= inp_nxt;
    rej_r      <= rej_nxt;
    chg_r      <= chg_nxt;
    out_r      <= out_nxt;
    idx_r      <= idx_nxt;
    seg_pct_r  <= seg_pct_nxt;
    up_r       <= up_nxt;
    span_mv_r  <= span_mv_nxt;
    rise_pct_r <= rise_pct_nxt;
    prod_r     <= prod_nxt;
    neg_r      <= neg_nxt;
    new_pct_r  <= new_pct_nxt;
    rem_r      <= rem_nxt;
    shf_r      <= shf_nxt;
    div_r      <= div_nxt;
    cnt_r      <= cnt_nxt;
  end

  // channel ports
  assign in_chan.ready    = (state_r == S_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

  // divider remainder always below the divisor while iterating
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  // a reading once accepted stays valid
  a_have_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |=> have_r)
    else $error("reading valid dropped");

  // status masks never lose bits
  a_mask_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((seen1_r & $past(seen1_r)) == $past(seen1_r))
          && ((seen2_r & $past(seen2_r)) == $past(seen2_r)))
    else $error("status mask lost a bit");

  // a rejected sample never changes the shown percent
  a_rej_chg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.sample_rejected && out_r.shown_changed))
    else $error("rejected sample changed shown percent");

  // a change of the shown percent implies a valid reading
  a_chg_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.shown_changed) |-> out_r.reading_valid)
    else $error("shown percent changed without a reading");

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for battery_voltage_gauge_core. Polls go in over a
// valid/ready channel, and each one is run through a cycle-free gauge model
// kept in the bench (window check, running average, curve interpolation,
// hysteresis, sticky status masks). Every reading that comes out is compared
// field by field with the oldest predicted reading. Directed polls cover the
// corner cases first. Random polls follow under a range of curve, window and
// hysteresis settings and idling mixes on both sides of the block.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bvg_pkg::*;

  localparam int ANCHOR_COUNT  = ANCHORS_DEF;
  localparam int SETTLE_CYCLES = ANCHOR_COUNT + 37;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_REPORTS   = 10;
  localparam int MV_MAX        = 16383;
  localparam int MAX_GAP       = 60;
  localparam int RANDOM_ROUNDS = 9;
  localparam int ROUND_POLLS   = 103;

  localparam logic [CFG_IDX_W-1:0] CURVE_IDX [4] = '{CFG_CURVE_A, CFG_CURVE_B,
                                                     CFG_CURVE_C, CFG_CURVE_D};

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bvg_chan_if #(.payload_t(bvg_in_t))  poll_chan ();
  bvg_chan_if #(.payload_t(bvg_out_t)) gauge_chan ();

  battery_voltage_gauge_core #(
    .ANCHORS (ANCHOR_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (poll_chan),
    .out_chan  (gauge_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // run bookkeeping
  int unsigned cycle_count  = 0;
  int unsigned mismatches   = 0;
  int unsigned polls_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned phases_run   = 0;
  int          idle_pct     = 0;
  int          stall_pct    = 0;

  // register mirror
  logic [CURVE_W-1:0] curve_reg [4];
  logic [MV_W-1:0]    win_lo;
  logic [MV_W-1:0]    win_hi;
  logic [PCT_W-1:0]   hyst_step;

  // gauge state mirror
  logic [MV_W-1:0]    avg_mv;
  logic [PCT_W-1:0]   disp_pct;
  logic               reading_seen;
  logic [7:0]         status_one_mask;
  logic [7:0]         status_two_mask;

  bvg_out_t pending_readings [$];

  // curve staging and random voltage walk
  int anchor_mv_set  [8];
  int anchor_pct_set [8];
  int drift_mv = 3700;
  int span_lo  = 0;
  int span_hi  = MV_MAX;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings still pending",
               cycle_count, pending_readings.size());
      $display("battery_voltage_gauge_core test failed");
      $finish;
    end
  end

  function automatic int clamp_mv(input int mv);
    if (mv < 0) return 0;
    if (mv > MV_MAX) return MV_MAX;
    return mv;
  endfunction

  // percent from the averaged voltage: rounded interpolation over the anchors
  function automatic int curve_percent(input logic [MV_W-1:0] mv);
    int               amv  [8];
    int               apct [8];
    logic [ANC_W-1:0] word;
    int               mv_i;
    int               last;
    int               span_mv;
    int               pct_delta;
    int               level;
    mv_i = int'(mv);
    last = ANCHOR_COUNT - 1;
    for (int k = 0; k < 8; k++) begin
      word    = (k % 2 == 1) ? curve_reg[k / 2][CURVE_W-1:ANC_W] : curve_reg[k / 2][ANC_W-1:0];
      amv[k]  = int'(word[MV_W-1:0]);
      apct[k] = int'(word[ANC_W-1:MV_W]);
    end
    if (mv_i >= amv[0]) return apct[0];
    if (mv_i <= amv[last]) return apct[last];
    for (int i = 1; i < ANCHOR_COUNT; i++) begin
      if (mv_i >= amv[i]) begin
        span_mv   = amv[i-1] - amv[i];
        pct_delta = apct[i-1] - apct[i];
        if (span_mv <= 0) return apct[i];
        level = apct[i] + ((mv_i - amv[i]) * pct_delta + span_mv / 2) / span_mv;
        if (level < 0) level = 0;
        if (level > 127) level = 127;
        return level;
      end
    end
    return 0;
  endfunction

  // expected reading for one accepted poll, advances the state mirror
  function automatic bvg_out_t predict_gauge(input bvg_in_t p);
    bvg_out_t        r;
    logic [MV_W-1:0] raw;
    int              pct;
    int              diff;
    int              step;
    r = '0;
    if (p.voltage_ok) begin
      raw = MV_W'({p.voltage_high & VHI_MASK, p.voltage_low});
      if (p.status_one_ok) status_one_mask |= p.status_one;
      if (p.status_two_ok) status_two_mask |= p.status_two;
      if (raw < win_lo || raw > win_hi) begin
        r.sample_rejected = 1'b1;
      end else begin
        if (avg_mv == '0 || EMA_WEIGHT >= EMA_SCALE) begin
          avg_mv = raw;
        end else begin
          avg_mv = MV_W'((int'(avg_mv) * (EMA_SCALE - EMA_WEIGHT) + int'(raw) * EMA_WEIGHT)
                         / EMA_SCALE);
        end
        pct = curve_percent(avg_mv);
        if (!reading_seen) begin
          disp_pct        = PCT_W'(pct);
          reading_seen    = 1'b1;
          r.shown_changed = 1'b1;
        end else begin
          diff = pct - int'(disp_pct);
          step = int'(hyst_step);
          if (diff >= step || diff <= -step) begin
            disp_pct        = PCT_W'(pct);
            r.shown_changed = 1'b1;
          end
        end
      end
    end
    r.reading_valid   = reading_seen;
    r.filtered_mv     = avg_mv;
    r.shown_pct       = disp_pct;
    r.status_one_seen = status_one_mask;
    r.status_two_seen = status_two_mask;
    return r;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on reading %0d, %s: expected %0d, got %0d",
                 results_seen, name, want, got);
    end
  endfunction

  // reading checker and receiver stalls
  always @(posedge clk) begin
    bvg_out_t want;
    bvg_out_t got;
    if (rst_n && gauge_chan.valid && gauge_chan.ready) begin
      got = gauge_chan.payload;
      results_seen++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("reading %0d arrived with no poll waiting: %h", results_seen, got);
      end else begin
        want = pending_readings.pop_front();
        check_field("reading_valid", want.reading_valid, got.reading_valid);
        check_field("filtered_mv", want.filtered_mv, got.filtered_mv);
        check_field("shown_pct", want.shown_pct, got.shown_pct);
        check_field("sample_rejected", want.sample_rejected, got.sample_rejected);
        check_field("shown_changed", want.shown_changed, got.shown_changed);
        check_field("status_one_seen", want.status_one_seen, got.status_one_seen);
        check_field("status_two_seen", want.status_two_seen, got.status_two_seen);
      end
    end
    gauge_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic set_idling(input idling_t mix);
    case (mix)
      IDLE_NONE: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        idle_pct  = 81;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        idle_pct  = 0;
        stall_pct = 81;
      end
      default: begin
        idle_pct  = 10;
        stall_pct = 10;
      end
    endcase
  endtask

  // register write, also updates the mirror
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_CURVE_A, CFG_CURVE_B, CFG_CURVE_C, CFG_CURVE_D: curve_reg[idx[1:0]] = data;
      CFG_MIN_MV: win_lo    = data[MV_W-1:0];
      CFG_MAX_MV: win_hi    = data[MV_W-1:0];
      CFG_HYST:   hyst_step = data[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_window(input int lo, input int hi, input int hyst);
    write_reg(CFG_MIN_MV, CFG_DATA_W'(lo));
    write_reg(CFG_MAX_MV, CFG_DATA_W'(hi));
    write_reg(CFG_HYST, CFG_DATA_W'(hyst));
  endtask

  // packs the staged anchors two per register
  task automatic set_curve();
    logic [CURVE_W-1:0] pair;
    for (int j = 0; j < 4; j++) begin
      pair = {PCT_W'(anchor_pct_set[2*j+1]), MV_W'(clamp_mv(anchor_mv_set[2*j+1])),
              PCT_W'(anchor_pct_set[2*j]), MV_W'(clamp_mv(anchor_mv_set[2*j]))};
      write_reg(CURVE_IDX[j], pair);
    end
  endtask

  // one poll transfer, then a random sender gap
  task automatic send_poll(input bvg_in_t p);
    int gap;
    poll_chan.payload <= p;
    poll_chan.valid   <= 1'b1;
    do @(posedge clk); while (!poll_chan.ready);
    pending_readings.push_back(predict_gauge(p));
    polls_sent++;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      poll_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain all readings and let the sequencer go idle
  task automatic settle();
    poll_chan.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    phases_run++;
  endtask

  function automatic bvg_in_t poll_of(input logic ok, input int mv,
                                      input logic s1_ok, input logic [7:0] s1,
                                      input logic s2_ok, input logic [7:0] s2);
    bvg_in_t p;
    p.voltage_ok    = ok;
    p.voltage_high  = {2'($urandom), 6'(mv >> 8)};
    p.voltage_low   = 8'(mv);
    p.status_one_ok = s1_ok;
    p.status_one    = s1;
    p.status_two_ok = s2_ok;
    p.status_two    = s2;
    return p;
  endfunction

  // mostly quiet status bytes so the sticky masks fill slowly
  function automatic logic [7:0] status_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return 8'h00;
    if (pick < 95) return 8'h01 << $urandom_range(0, 7);
    return 8'($urandom);
  endfunction

  function automatic bvg_in_t random_poll();
    int mv;
    int pick;
    if ($urandom_range(0, 49) == 0) drift_mv = $urandom_range(span_lo, span_hi);
    drift_mv = clamp_mv(drift_mv + int'($urandom_range(0, 60)) - 30);
    pick = $urandom_range(0, 99);
    if (pick < 70) mv = clamp_mv(drift_mv + int'($urandom_range(0, 80)) - 40);
    else if (pick < 90) mv = $urandom_range(span_lo, span_hi);
    else mv = $urandom_range(0, MV_MAX);
    return poll_of($urandom_range(0, 99) < 90, mv, 1'($urandom), status_byte(),
                   1'($urandom), status_byte());
  endfunction

  // standard descending discharge curve
  task automatic load_standard_curve();
    anchor_mv_set  = '{4200, 4000, 3850, 3750, 3650, 3550, 3400, 3200};
    anchor_pct_set = '{100, 85, 70, 50, 30, 15, 5, 0};
    set_curve();
  endtask

  // reset values: zero curve, default window; nothing accepted yet
  task automatic test_reset_defaults();
    set_idling(IDLE_NONE);
    send_poll(poll_of(1'b0, 3500, 1'b1, 8'hFF, 1'b1, 8'hFF));
    send_poll(poll_of(1'b1, 2999, 1'b1, 8'h01, 1'b0, 8'h80));
    send_poll(poll_of(1'b1, 4501, 1'b0, 8'h40, 1'b1, 8'h02));
    send_poll(poll_of(1'b1, MV_MAX, 1'b1, 8'h00, 1'b1, 8'h00));
    settle();
  endtask

  // accepted zero keeps the average empty, the next good sample seeds it
  task automatic test_zero_voltage();
    set_idling(IDLE_SENDER);
    set_window(0, MV_MAX, 2);
    send_poll(poll_of(1'b1, 0, 1'b1, 8'h10, 1'b1, 8'h00));
    send_poll(poll_of(1'b1, 0, 1'b0, 8'h00, 1'b1, 8'h04));
    send_poll(poll_of(1'b1, 3800, 1'b0, 8'h00, 1'b0, 8'h00));
    settle();
  endtask

  // window edges with the standard curve
  task automatic test_window_edges();
    set_idling(IDLE_RECEIVER);
    load_standard_curve();
    set_window(3000, 4500, 2);
    send_poll(poll_of(1'b1, 3000, 1'b0, 8'h00, 1'b0, 8'h00));
    send_poll(poll_of(1'b1, 4500, 1'b1, 8'h20, 1'b0, 8'h00));
    send_poll(poll_of(1'b1, 2999, 1'b0, 8'h00, 1'b1, 8'h08));
    send_poll(poll_of(1'b1, 4501, 1'b0, 8'h00, 1'b0, 8'h00));
    send_poll(poll_of(1'b1, 3500, 1'b0, 8'h00, 1'b0, 8'h00));
    settle();
  endtask

  // zero step rewrites every time, full step holds the shown value
  task automatic test_hysteresis_extremes();
    set_idling(IDLE_BOTH);
    write_reg(CFG_HYST, CFG_DATA_W'(0));
    send_poll(poll_of(1'b1, int'(avg_mv), 1'b0, 8'h00, 1'b0, 8'h00));
    send_poll(poll_of(1'b1, int'(avg_mv), 1'b0, 8'h00, 1'b0, 8'h00));
    settle();
    write_reg(CFG_HYST, CFG_DATA_W'(100));
    send_poll(poll_of(1'b1, 4200, 1'b0, 8'h00, 1'b0, 8'h00));
    send_poll(poll_of(1'b1, 3200, 1'b0, 8'h00, 1'b0, 8'h00));
    settle();
  endtask

  // minimum above maximum rejects everything
  task automatic test_empty_window();
    set_idling(IDLE_SENDER);
    set_window(4000, 3999, 1);
    send_poll(poll_of(1'b1, 4000, 1'b0, 8'h00, 1'b0, 8'h00));
    send_poll(poll_of(1'b1, 3999, 1'b0, 8'h00, 1'b0, 8'h00));
    settle();
  endtask

  // curves placed around the current average, which a sample equal to it keeps
  task automatic test_odd_curves();
    int e;
    set_idling(IDLE_RECEIVER);
    set_window(0, MV_MAX, 1);
    e = int'(avg_mv);
    // percent above 100 passes through
    for (int k = 0; k < 8; k++) begin
      anchor_mv_set[k]  = e - 10 - 150 * k;
      anchor_pct_set[k] = 127 - 15 * k;
    end
    set_curve();
    send_poll(poll_of(1'b1, e, 1'b0, 8'h00, 1'b0, 8'h00));
    settle();
    // rising anchor pair and percent that climbs toward lower voltage
    anchor_mv_set[0] = e + 300;
    anchor_pct_set[0] = 100;
    anchor_mv_set[1] = e + 400;
    anchor_pct_set[1] = 10;
    for (int k = 2; k < 8; k++) begin
      anchor_mv_set[k]  = e - 100 * (k - 1);
      anchor_pct_set[k] = 70 - 10 * (k - 2);
    end
    set_curve();
    send_poll(poll_of(1'b1, e, 1'b0, 8'h00, 1'b0, 8'h00));
    settle();
    // last anchor above the voltage
    for (int k = 0; k < 8; k++) begin
      anchor_mv_set[k]  = e + 100 - 10 * k;
      anchor_pct_set[k] = 100 - 10 * k;
    end
    set_curve();
    send_poll(poll_of(1'b1, e, 1'b0, 8'h00, 1'b0, 8'h00));
    settle();
  endtask

  // random curve, window and step for one round
  task automatic random_setting(input int round);
    int top;
    int pct;
    int lo;
    int hi;
    int hyst;
    if (round % 4 == 3) begin
      for (int j = 0; j < 4; j++) write_reg(CURVE_IDX[j], CFG_DATA_W'({$urandom, $urandom}));
    end else begin
      top = $urandom_range(3900, 4400);
      pct = ($urandom_range(0, 4) == 0) ? 127 : $urandom_range(85, 100);
      for (int k = 0; k < 8; k++) begin
        anchor_mv_set[k]  = top;
        anchor_pct_set[k] = pct;
        top = clamp_mv(top - int'($urandom_range(0, 250)));
        pct = pct - int'($urandom_range(0, 25));
        if (pct < 0) pct = 0;
      end
      set_curve();
    end
    case (round % 3)
      0: begin
        lo = clamp_mv(anchor_mv_set[7] - 100);
        hi = clamp_mv(anchor_mv_set[0] + 100);
      end
      1: begin
        lo = 0;
        hi = MV_MAX;
      end
      default: begin
        lo = $urandom_range(2500, 4800);
        hi = $urandom_range(2500, 4800);
      end
    endcase
    case ($urandom_range(0, 5))
      0:       hyst = 0;
      1:       hyst = 100;
      default: hyst = $urandom_range(1, 6);
    endcase
    set_window(lo, hi, hyst);
    span_lo  = clamp_mv(((lo < hi) ? lo : hi) - 150);
    span_hi  = clamp_mv(((lo < hi) ? hi : lo) + 150);
    drift_mv = $urandom_range(span_lo, span_hi);
  endtask

  // random polls over several settings and all idling mixes
  task automatic test_random_traffic();
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      random_setting(round);
      set_idling(idling_t'(round % 4));
      repeat (ROUND_POLLS) send_poll(random_poll());
      settle();
    end
  endtask

  initial begin
    poll_chan.valid   <= 1'b0;
    poll_chan.payload <= '0;
    for (int j = 0; j < 4; j++) curve_reg[j] = '0;
    win_lo          = MIN_MV_RST;
    win_hi          = MAX_MV_RST;
    hyst_step       = HYST_RST;
    avg_mv          = '0;
    disp_pct        = '0;
    reading_seen    = 1'b0;
    status_one_mask = '0;
    status_two_mask = '0;

    // synchronous reset
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_zero_voltage();
    test_window_edges();
    test_hysteresis_extremes();
    test_empty_window();
    test_odd_curves();
    test_random_traffic();

    mismatches += pending_readings.size();
    $display("covered %0d polls and checked %0d readings over %0d configuration phases,",
             polls_sent, results_seen, phases_run);
    $display("with sender gaps and receiver stalls in four mixes; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("battery_voltage_gauge_core test passed");
    end else begin
      $display("battery_voltage_gauge_core test failed");
    end
    $finish;
  end

endmodule
